// ===== rtl/rab_pkg.sv =====
package rab_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned LevelW = 9;
  localparam int unsigned WtW    = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 9;

  localparam logic [LevelW-1:0] LevelFull = 9'd256;
  localparam logic [PixW-1:0]   AlphaMax  = 8'd255;

  localparam logic [CfgIdxW-1:0] IdxLevel = 1'b0;
  localparam logic [CfgIdxW-1:0] IdxMode  = 1'b1;

  typedef enum logic {
    ModeRgb  = 1'b0,
    ModeRgba = 1'b1
  } mode_e;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

// ===== rtl/rab_if.sv =====
interface rab_in_if;
  logic                       valid;
  logic                       ready;
  logic [rab_pkg::PixW-1:0]   bottom_red;
  logic [rab_pkg::PixW-1:0]   bottom_green;
  logic [rab_pkg::PixW-1:0]   bottom_blue;
  logic [rab_pkg::PixW-1:0]   top_red;
  logic [rab_pkg::PixW-1:0]   top_green;
  logic [rab_pkg::PixW-1:0]   top_blue;
  logic [rab_pkg::PixW-1:0]   top_alpha;

  modport source (
    output valid, bottom_red, bottom_green, bottom_blue,
           top_red, top_green, top_blue, top_alpha,
    input  ready
  );
  modport sink (
    input  valid, bottom_red, bottom_green, bottom_blue,
           top_red, top_green, top_blue, top_alpha,
    output ready
  );
endinterface

interface rab_out_if;
  logic                       valid;
  logic                       ready;
  logic [rab_pkg::PixW-1:0]   out_red;
  logic [rab_pkg::PixW-1:0]   out_green;
  logic [rab_pkg::PixW-1:0]   out_blue;
  logic                       write_enable;

  modport source (
    output valid, out_red, out_green, out_blue, write_enable,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, write_enable,
    output ready
  );
endinterface

// ===== rtl/rgb_alpha_blend_unit.sv =====
// RGB alpha blend unit.
// pix_i carries one bottom pixel, one top pixel and the top alpha per
// transfer; pix_o returns the blended RGB and a write enable per transfer.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 blend level, 1 channel mode) at the clock edge; write only while idle.
// Four register stages: weight/capture, mix multiply, divide-by-255
// estimate, correction into the output register, which drives pix_o.
// Throughput is one pixel per clock while the receiver is ready; every
// stage holds its own valid bit and empty stages fill while the output waits.
// When the receiver stalls, the pipeline keeps advancing into empty stages
// and holds full ones; pix_i.ready drops only once all four stages are full.
// Nothing is lost or repeated.
// Reset empties the pipeline, sets the level to 256 (full opacity) and
// selects three-channel mode.
module rgb_alpha_blend_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rab_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [rab_pkg::CfgDataW-1:0]    cfg_data_i,
  rab_in_if.sink                          pix_i,
  rab_out_if.source                       pix_o
);

  logic [rab_pkg::LevelW-1:0] level_q;
  rab_pkg::mode_e             mode_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;
  rab_pkg::stage_en_t en;

  logic [rab_pkg::WtW-1:0] wt1;
  logic we1, we2_q, we3_q, we4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= rab_pkg::LevelFull;
      mode_q  <= rab_pkg::ModeRgb;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rab_pkg::IdxLevel: level_q <= cfg_data_i[rab_pkg::LevelW-1:0];
        rab_pkg::IdxMode:  mode_q  <= rab_pkg::mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    adv4  = !v4_q || pix_o.ready;
    adv3  = !v3_q || adv4;
    adv2  = !v2_q || adv3;
    adv1  = !v1_q || adv2;
    en.s1 = adv1 && pix_i.valid;
    en.s2 = adv2 && v1_q;
    en.s3 = adv3 && v2_q;
    en.s4 = adv4 && v3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= pix_i.valid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s2) we2_q <= we1;
    if (en.s3) we3_q <= we2_q;
    if (en.s4) we4_q <= we3_q;
  end

  rab_weight u_weight (
    .clk_i   (clk_i),
    .en_i    (en.s1),
    .level_i (level_q),
    .mode_i  (mode_q),
    .alpha_i (pix_i.top_alpha),
    .wt_o    (wt1),
    .we_o    (we1)
  );

  rab_channel u_red (
    .clk_i    (clk_i),
    .en_i     (en),
    .bottom_i (pix_i.bottom_red),
    .top_i    (pix_i.top_red),
    .wt_i     (wt1),
    .out_o    (pix_o.out_red)
  );

  rab_channel u_green (
    .clk_i    (clk_i),
    .en_i     (en),
    .bottom_i (pix_i.bottom_green),
    .top_i    (pix_i.top_green),
    .wt_i     (wt1),
    .out_o    (pix_o.out_green)
  );

  rab_channel u_blue (
    .clk_i    (clk_i),
    .en_i     (en),
    .bottom_i (pix_i.bottom_blue),
    .top_i    (pix_i.top_blue),
    .wt_i     (wt1),
    .out_o    (pix_o.out_blue)
  );

  assign pix_i.ready        = adv1;
  assign pix_o.valid        = v4_q;
  assign pix_o.write_enable = we4_q;

endmodule

// ===== rtl/rab_weight.sv =====
module rab_weight (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [rab_pkg::LevelW-1:0]    level_i,
  input  rab_pkg::mode_e                mode_i,
  input  logic [rab_pkg::PixW-1:0]      alpha_i,
  output logic [rab_pkg::WtW-1:0]       wt_o,
  output logic                          we_o
);

  // Weight in units of 1/65280 for both modes.
  logic [rab_pkg::LevelW-1:0]           lvl_sat;
  logic [rab_pkg::PixW-1:0]             a_sel;
  logic [rab_pkg::PixW+rab_pkg::LevelW-1:0] prod;
  logic [rab_pkg::WtW-1:0]              wt_d, wt_q;
  logic                                 we_d, we_q;

  always_comb begin
    lvl_sat = (level_i > rab_pkg::LevelFull) ? rab_pkg::LevelFull : level_i;
    a_sel   = (mode_i == rab_pkg::ModeRgba) ? alpha_i : rab_pkg::AlphaMax;
    prod    = a_sel * lvl_sat;
    wt_d    = prod[rab_pkg::WtW-1:0];
    we_d    = (mode_i == rab_pkg::ModeRgba) ? (alpha_i != '0) : 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wt_q <= wt_d;
      we_q <= we_d;
    end
  end

  assign wt_o = wt_q;
  assign we_o = we_q;

endmodule

// ===== rtl/rab_channel.sv =====
module rab_channel (
  input  logic                      clk_i,
  input  rab_pkg::stage_en_t        en_i,
  input  logic [rab_pkg::PixW-1:0]  bottom_i,
  input  logic [rab_pkg::PixW-1:0]  top_i,
  input  logic [rab_pkg::WtW-1:0]   wt_i,
  output logic [rab_pkg::PixW-1:0]  out_o
);

  localparam int unsigned NumW = 24;
  localparam int unsigned SumW = 26;

  logic [rab_pkg::PixW-1:0] b1_q, t1_q;
  logic [rab_pkg::WtW-1:0]  x2_d, x2_q, x3_q;
  logic [rab_pkg::PixW-1:0] q3_d, q3_q;
  logic [rab_pkg::PixW-1:0] out_d, out_q;

  logic signed [rab_pkg::PixW:0]   diff;
  logic signed [rab_pkg::WtW:0]    wt_s;
  logic signed [SumW-1:0]          prod;
  logic [NumW-1:0]                 base;
  logic signed [SumW-1:0]          sum;
  logic [NumW-1:0]                 recip;
  logic [rab_pkg::WtW-1:0]         rem;

  // Stage 2: num = b*65280 + (t-b)*wt, keep num/256
  always_comb begin
    diff = $signed({1'b0, t1_q}) - $signed({1'b0, b1_q});
    wt_s = $signed({1'b0, wt_i});
    prod = SumW'(diff * wt_s);
    base = {b1_q, 16'h0000} - {8'h00, b1_q, 8'h00};
    sum  = $signed({2'b00, base}) + prod;
    x2_d = sum[rab_pkg::WtW+7:8];
  end

  // Stage 3: estimate x/255 as (x*257)>>16, low by at most one
  always_comb begin
    recip = {8'h00, x2_q} + {x2_q, 8'h00};
    q3_d  = recip[NumW-1:rab_pkg::WtW];
  end

  // Stage 4: remainder correction
  always_comb begin
    rem   = x3_q - {q3_q, 8'h00} + {8'h00, q3_q};
    out_d = (rem >= 16'd255) ? q3_q + 8'd1 : q3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      b1_q <= bottom_i;
      t1_q <= top_i;
    end
    if (en_i.s2) begin
      x2_q <= x2_d;
    end
    if (en_i.s3) begin
      x3_q <= x2_q;
      q3_q <= q3_d;
    end
    if (en_i.s4) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// ===== tb/tb_rgb_alpha_blend_unit.sv =====
module tb_rgb_alpha_blend_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 500000;

  typedef logic [rab_pkg::PixW-1:0] byte_t;

  typedef struct packed {
    byte_t bottom_red;
    byte_t bottom_green;
    byte_t bottom_blue;
    byte_t top_red;
    byte_t top_green;
    byte_t top_blue;
    byte_t top_alpha;
  } pixel_t;

  typedef struct packed {
    byte_t out_red;
    byte_t out_green;
    byte_t out_blue;
    logic  write_enable;
  } blended_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [rab_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [rab_pkg::CfgDataW-1:0] cfg_data_i;

  rab_in_if  pix_in ();
  rab_out_if pix_out ();

  rgb_alpha_blend_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_in),
    .pix_o      (pix_out)
  );

  always #5ns clk_i = ~clk_i;

  // register mirror
  logic [rab_pkg::LevelW-1:0] level_q;
  rab_pkg::mode_e             mode_q;

  pixel_t   pixel_queue[$];
  blended_t blend_expect[$];

  int unsigned mismatch_count = 0;
  int unsigned sent_count     = 0;
  int unsigned checked_count  = 0;
  int unsigned masked_count   = 0;
  int unsigned phase_count    = 0;
  int unsigned cycle_count    = 0;
  bit          no_idle        = 1'b0;

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic byte_t mix_byte(byte_t bottom, byte_t top, int unsigned wt,
                                     int unsigned den);
    int unsigned sum;
    sum = int'(bottom) * (den - wt) + int'(top) * wt;
    return byte_t'(sum / den);
  endfunction

  function automatic blended_t blend_pixel(pixel_t p);
    int unsigned lvl;
    int unsigned wt;
    int unsigned den;
    blended_t    r;
    lvl = (level_q > rab_pkg::LevelFull) ? int'(rab_pkg::LevelFull) : int'(level_q);
    if (mode_q == rab_pkg::ModeRgb) begin
      wt = lvl;
      den = int'(rab_pkg::LevelFull);
      r.write_enable = 1'b1;
    end else begin
      wt = int'(p.top_alpha) * lvl;
      den = int'(rab_pkg::AlphaMax) * int'(rab_pkg::LevelFull);
      r.write_enable = (p.top_alpha != '0);
    end
    r.out_red   = mix_byte(p.bottom_red, p.top_red, wt, den);
    r.out_green = mix_byte(p.bottom_green, p.top_green, wt, den);
    r.out_blue  = mix_byte(p.bottom_blue, p.top_blue, wt, den);
    return r;
  endfunction

  function automatic byte_t rand_byte();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.bottom_red   = rand_byte();
    p.bottom_green = rand_byte();
    p.bottom_blue  = rand_byte();
    p.top_red      = rand_byte();
    p.top_green    = rand_byte();
    p.top_blue     = rand_byte();
    case ($urandom_range(0, 7))
      0: p.top_alpha = '0;
      1: p.top_alpha = '1;
      2: p.top_alpha = 8'd1;
      default: p.top_alpha = byte_t'($urandom_range(0, 255));
    endcase
    return p;
  endfunction

  task automatic queue_pixel(byte_t br, byte_t bg, byte_t bb, byte_t tr, byte_t tg,
                             byte_t tb, byte_t ta);
    pixel_queue.push_back('{br, bg, bb, tr, tg, tb, ta});
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) pixel_queue.push_back(rand_pixel());
  endtask

  task automatic write_reg(logic [rab_pkg::CfgIdxW-1:0] idx,
                           logic [rab_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == rab_pkg::IdxLevel) level_q = data[rab_pkg::LevelW-1:0];
    else mode_q = rab_pkg::mode_e'(data[0]);
  endtask

  task automatic set_config(logic [rab_pkg::CfgDataW-1:0] level,
                            logic [rab_pkg::CfgDataW-1:0] mode, bit burst);
    write_reg(rab_pkg::IdxLevel, level);
    write_reg(rab_pkg::IdxMode, mode);
    no_idle = burst;
    phase_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pixel_queue.size() != 0 || pix_in.valid || blend_expect.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // input driver
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin : pixel_driver
    pixel_t p;
    if (!rst_ni) begin
      pix_in.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        p = '{pix_in.bottom_red, pix_in.bottom_green, pix_in.bottom_blue,
              pix_in.top_red, pix_in.top_green, pix_in.top_blue, pix_in.top_alpha};
        blend_expect.push_back(blend_pixel(p));
        sent_count++;
      end
      if (!pix_in.valid || pix_in.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_in.valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          p = pixel_queue.pop_front();
          pix_in.valid        <= 1'b1;
          pix_in.bottom_red   <= p.bottom_red;
          pix_in.bottom_green <= p.bottom_green;
          pix_in.bottom_blue  <= p.bottom_blue;
          pix_in.top_red      <= p.top_red;
          pix_in.top_green    <= p.top_green;
          pix_in.top_blue     <= p.top_blue;
          pix_in.top_alpha    <= p.top_alpha;
          gap_left = no_idle ? 0 : $urandom_range(0, 10);
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin : result_monitor
    blended_t want;
    if (!rst_ni) begin
      pix_out.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (blend_expect.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = blend_expect.pop_front();
          checked_count++;
          if (!pix_out.write_enable) masked_count++;
          if (pix_out.out_red !== want.out_red)
            report_mismatch($sformatf("out_red %0d, expected %0d", pix_out.out_red,
                                      want.out_red));
          if (pix_out.out_green !== want.out_green)
            report_mismatch($sformatf("out_green %0d, expected %0d", pix_out.out_green,
                                      want.out_green));
          if (pix_out.out_blue !== want.out_blue)
            report_mismatch($sformatf("out_blue %0d, expected %0d", pix_out.out_blue,
                                      want.out_blue));
          if (pix_out.write_enable !== want.write_enable)
            report_mismatch($sformatf("write_enable %b, expected %b",
                                      pix_out.write_enable, want.write_enable));
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (stall_left > 0) begin
        stall_left--;
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               blend_expect.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = rab_pkg::IdxLevel;
    cfg_data_i          = '0;
    pix_in.valid        = 1'b0;
    pix_in.bottom_red   = '0;
    pix_in.bottom_green = '0;
    pix_in.bottom_blue  = '0;
    pix_in.top_red      = '0;
    pix_in.top_green    = '0;
    pix_in.top_blue     = '0;
    pix_in.top_alpha    = '0;
    pix_out.ready       = 1'b0;
    level_q             = rab_pkg::LevelFull;
    mode_q              = rab_pkg::ModeRgb;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset configuration: full level, three-channel, alpha ignored
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    queue_pixel(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0);
    queue_pixel(8'd17, 8'd200, 8'd99, 8'd250, 8'd3, 8'd128, 8'd0);
    wait_drained();

    set_config(9'd128, 9'h1FE, 1'b0);
    queue_pixel(8'd255, 8'd0, 8'd1, 8'd0, 8'd255, 8'd254, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0);
    queue_random(150);
    wait_drained();

    set_config(9'd0, 9'd0, 1'b0);
    queue_pixel(8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd7, 8'd255);
    queue_random(100);
    wait_drained();

    // level above full saturates
    set_config(9'd511, 9'd0, 1'b0);
    queue_pixel(8'd0, 8'd255, 8'd10, 8'd255, 8'd0, 8'd20, 8'd0);
    queue_random(120);
    wait_drained();

    set_config(9'd257, 9'h001, 1'b0);
    queue_pixel(8'd10, 8'd20, 8'd30, 8'd200, 8'd210, 8'd220, 8'd0);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd1);
    queue_pixel(8'd0, 8'd255, 8'd100, 8'd255, 8'd0, 8'd200, 8'd128);
    queue_random(150);
    wait_drained();

    set_config(9'd256, 9'h1FF, 1'b1);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd254);
    queue_random(200);
    wait_drained();

    set_config(9'd0, 9'd1, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
    queue_random(100);
    wait_drained();

    set_config(9'd1, 9'd1, 1'b0);
    queue_random(150);
    wait_drained();

    set_config(9'd300, 9'd0, 1'b1);
    queue_random(100);
    wait_drained();

    repeat (6) begin
      set_config(rab_pkg::CfgDataW'($urandom_range(0, 511)),
                 rab_pkg::CfgDataW'($urandom_range(0, 511)),
                 ($urandom_range(0, 3) == 0));
      queue_random(140);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (blend_expect.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", blend_expect.size()));
    $display("%0d pixels blended over %0d level/mode settings, %0d cycles",
             sent_count, phase_count + 1, cycle_count);
    $display("%0d results checked, %0d with write enable cleared, %0d mismatches",
             checked_count, masked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== rgb_alpha_blend_unit.f =====
rtl/rab_pkg.sv
rtl/rab_if.sv
rtl/rab_weight.sv
rtl/rab_channel.sv
rtl/rgb_alpha_blend_unit.sv
tb/tb_rgb_alpha_blend_unit.sv
